FILE: design/sha256_message_hasher_assert.svh
// Assertion macros shared by the hasher RTL.
`ifndef SHA256_MESSAGE_HASHER_ASSERT_SVH
`define SHA256_MESSAGE_HASHER_ASSERT_SVH
`define SHA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: design/sha_pkg.sv
package sha_pkg;
    typedef struct packed {
        logic [7:0] msg_byte;
        logic       byte_valid;
        logic       end_of_message;
    } t_in;
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out;
    localparam logic [255:0] INIT_H = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
endpackage

FILE: design/sha256_message_hasher.sv
// SHA-256 hasher. The input channel (i_valid, o_stall, i_data) takes one
// transaction per message byte; end_of_message closes the message, and an
// end transaction without a byte closes an empty or already complete message.
// The output channel (o_valid, i_stall, o_data) carries the eight digest
// words, index 0 first, last_word set on index 7.
// A byte that does not complete a 64-byte block is taken without a compression.
// The 64th byte of a block starts a compression: one shared round unit
// runs one round per cycle, then the S_ADD state adds the chaining words.
// An end transaction costs one padding step and one compression, or two of
// each when fewer than nine bytes of room remain, then eight output
// transactions, one per cycle while i_stall is low.
// o_stall is high whenever the block is busy padding, compressing or emitting.
// A stalled digest word holds on o_data until taken.
// Reset (synchronous, i_rst_n low) loads the initial hash values and clears
// the byte and bit counters and all control state; the block is idle after.
`include "sha256_message_hasher_assert.svh"
module sha256_message_hasher (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  sha_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output sha_pkg::t_out o_data
);
    import sha_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ROUND = 3'd1;
    localparam logic [2:0] S_ADD = 3'd2;
    localparam logic [2:0] S_PAD = 3'd3;
    localparam logic [2:0] S_OUT = 3'd4;

    logic [2:0]   r_state, n_state;
    logic [255:0] r_h, n_h;
    logic [255:0] r_v, n_v;
    logic [31:0]  r_w [16];
    logic [31:0]  n_w [16];
    logic [5:0]   r_cnt, n_cnt;
    logic [63:0]  r_bits, n_bits;
    logic [6:0]   r_round, n_round;
    logic         r_fin, n_fin;
    logic         r_second, n_second;
    logic [2:0]   r_oidx, n_oidx;

    logic [31:0] a, b, c, d, e, f, g, h, wt, s0, s1, t1, t2, ww;
    logic [3:0]  ti;
    logic [5:0]  rpos;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    assign {a, b, c, d, e, f, g, h} = r_v;
    assign ti = r_round[3:0];
    assign s0 = rotr(r_w[ti + 4'd1], 7) ^ rotr(r_w[ti + 4'd1], 18) ^ (r_w[ti + 4'd1] >> 3);
    assign s1 = rotr(r_w[ti + 4'd14], 17) ^ rotr(r_w[ti + 4'd14], 19)
        ^ (r_w[ti + 4'd14] >> 10);
    assign ww = r_w[ti] + s0 + r_w[ti + 4'd9] + s1;
    assign wt = (r_round < 7'd16) ? r_w[ti] : ww;
    assign t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
        + ROUND_K[r_round[5:0]] + wt;
    assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_data.digest_word = r_h[255 - 32 * r_oidx -: 32];
    assign o_data.word_index = r_oidx;
    assign o_data.last_word = (r_oidx == 3'd7);

    always_comb begin
        n_state = r_state;
        n_h = r_h;
        n_v = r_v;
        n_w = r_w;
        n_cnt = r_cnt;
        n_bits = r_bits;
        n_round = r_round;
        n_fin = r_fin;
        n_second = r_second;
        n_oidx = r_oidx;
        rpos = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_data.byte_valid) begin
                        if (r_cnt[1:0] == 2'd0) begin
                            n_w[r_cnt[5:2]] = {i_data.msg_byte, 24'd0};
                        end else begin
                            n_w[r_cnt[5:2]][31 - 8 * r_cnt[1:0] -: 8] = i_data.msg_byte;
                        end
                        n_bits = r_bits + 64'd8;
                        n_cnt = r_cnt + 6'd1;
                    end
                    n_fin = i_data.end_of_message;
                    n_second = 1'b0;
                    if (i_data.byte_valid && r_cnt == 6'd63) begin
                        n_state = S_ROUND;
                        n_v = r_h;
                        n_round = 7'd0;
                    end else if (i_data.end_of_message) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                if (!r_second) begin
                    if (rpos[1:0] == 2'd0) begin
                        n_w[rpos[5:2]] = 32'h8000_0000;
                    end else begin
                        n_w[rpos[5:2]][31 - 8 * rpos[1:0] -: 8] = 8'h80;
                    end
                    for (int k = 0; k < 16; k++) begin
                        if (k > int'(rpos[5:2])) begin
                            n_w[k] = 32'd0;
                        end
                    end
                    n_second = 1'b1;
                    if (rpos >= 6'd56) begin
                        n_state = S_ROUND;
                        n_v = r_h;
                        n_round = 7'd0;
                    end else begin
                        n_w[14] = r_bits[63:32];
                        n_w[15] = r_bits[31:0];
                        n_fin = 1'b0;
                        n_state = S_ROUND;
                        n_v = r_h;
                        n_round = 7'd0;
                    end
                end else begin
                    for (int k = 0; k < 14; k++) begin
                        n_w[k] = 32'd0;
                    end
                    n_w[14] = r_bits[63:32];
                    n_w[15] = r_bits[31:0];
                    n_fin = 1'b0;
                    n_state = S_ROUND;
                    n_v = r_h;
                    n_round = 7'd0;
                end
            end
            S_ROUND: begin
                if (r_round >= 7'd16) begin
                    n_w[ti] = ww;
                end
                n_v = {t1 + t2, a, b, c, d + t1, e, f, g};
                n_round = r_round + 7'd1;
                if (r_round == 7'd63) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                for (int k = 0; k < 8; k++) begin
                    n_h[32 * k +: 32] = r_h[32 * k +: 32] + r_v[32 * k +: 32];
                end
                n_round = 7'd0;
                if (r_fin) begin
                    n_state = S_PAD;
                end else if (r_second) begin
                    n_state = S_OUT;
                    n_oidx = 3'd0;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_oidx = r_oidx + 3'd1;
                    if (r_oidx == 3'd7) begin
                        n_state = S_IDLE;
                        n_h = INIT_H;
                        n_cnt = 6'd0;
                        n_bits = 64'd0;
                        n_second = 1'b0;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_h <= INIT_H;
            r_v <= '0;
            r_cnt <= '0;
            r_bits <= '0;
            r_round <= '0;
            r_fin <= 1'b0;
            r_second <= 1'b0;
            r_oidx <= '0;
        end else begin
            r_state <= n_state;
            r_h <= n_h;
            r_v <= n_v;
            r_cnt <= n_cnt;
            r_bits <= n_bits;
            r_round <= n_round;
            r_fin <= n_fin;
            r_second <= n_second;
            r_oidx <= n_oidx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w <= n_w;
    end

    `SHA_ASSERT_IMPL(a_round_range, i_clk, i_rst_n, r_state == S_ROUND, r_round < 7'd64)
    `SHA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(r_oidx))
    `SHA_ASSERT_NEXT(a_out_done, i_clk, i_rst_n, o_valid && !i_stall && o_data.last_word,
        r_state == S_IDLE && r_cnt == 6'd0)
endmodule
